// ===== rtl/ppc_pkg.sv =====
// Shared constants, codes and types for the polygon point containment block.
package ppc_pkg;

  // Default sizing
  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF   = 14;

  // A polygon needs at least this many vertices to enclose anything
  localparam int MIN_POLY_VERTICES = 3;

  // Operation codes carried by op
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // Status from the edge pipeline back to the sequencer
  typedef struct packed {
    logic busy;  // an edge is still in flight
    logic bnd;   // some edge passed through the query point
    logic odd;   // crossing parity so far
  } edge_stat_t;

endpackage

// ===== rtl/ppc_vram.sv =====
// Vertex store: one write port, one read port, registered read data.
module ppc_vram #(
  parameter int DEPTH = ppc_pkg::MAX_VERTICES_DEF,
  parameter int WIDTH = 2 * ppc_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata,
  output logic                     rvalid
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Marks the cycle in which rdata holds a fresh read
  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= re;
    end
  end

endmodule

// ===== rtl/ppc_edge.sv =====
// Edge pipeline: boundary and even-odd crossing test of one edge per cycle.
module ppc_edge #(
  parameter int COORD_BITS = ppc_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COORD_BITS-1:0]  a_init_x,
  input  logic [COORD_BITS-1:0]  a_init_y,
  input  logic [COORD_BITS-1:0]  p_x,
  input  logic [COORD_BITS-1:0]  p_y,
  input  logic                   b_valid,
  input  logic [COORD_BITS-1:0]  b_x,
  input  logic [COORD_BITS-1:0]  b_y,
  output ppc_pkg::edge_stat_t    stat
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // Previous vertex: start of the current edge
  logic [COORD_BITS-1:0] a_x, a_y;

  // Stage 1 registers
  logic                 s1_v;
  logic signed [DW-1:0] s1_dxb, s1_dyp, s1_dyb, s1_dxp;
  logic                 s1_box, s1_str, s1_dypos;

  // Stage 2 registers
  logic                 s2_v;
  logic signed [PW-1:0] s2_rhs, s2_lhs;
  logic                 s2_box, s2_str, s2_dypos;

  // Accumulators
  logic bnd, odd;

  // Stage 1 combinational terms
  logic signed [DW-1:0] ax_s, ay_s, bx_s, by_s, px_s, py_s;
  logic                 box, str, dypos;

  // Stage 3 combinational terms
  logic signed [PW:0]   diff;
  logic                 cr_zero, cr_pos, cr_neg, on_edge, hit;

  // Differences, bounding box and straddle check
  always_comb begin
    ax_s  = $signed({1'b0, a_x});
    ay_s  = $signed({1'b0, a_y});
    bx_s  = $signed({1'b0, b_x});
    by_s  = $signed({1'b0, b_y});
    px_s  = $signed({1'b0, p_x});
    py_s  = $signed({1'b0, p_y});
    box   = ((a_x <= p_x && p_x <= b_x) || (b_x <= p_x && p_x <= a_x)) &&
            ((a_y <= p_y && p_y <= b_y) || (b_y <= p_y && p_y <= a_y));
    str   = (a_y > p_y) != (b_y > p_y);
    dypos = b_y > a_y;
  end

  // Cross product sign and per-edge decisions
  always_comb begin
    diff    = {s2_rhs[PW-1], s2_rhs} - {s2_lhs[PW-1], s2_lhs};
    cr_zero = (diff == '0);
    cr_neg  = diff[PW];
    cr_pos  = !cr_neg && !cr_zero;
    on_edge = cr_zero && s2_box;
    hit     = s2_str && (s2_dypos ? cr_pos : cr_neg);
  end

  // Valid bits and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      bnd  <= 1'b0;
      odd  <= 1'b0;
    end else begin
      s1_v <= b_valid;
      s2_v <= s1_v;
      if (start) begin
        bnd <= 1'b0;
        odd <= 1'b0;
      end else if (s2_v) begin
        bnd <= bnd | on_edge;
        odd <= odd ^ hit;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      a_x <= a_init_x;
      a_y <= a_init_y;
    end else if (b_valid) begin
      a_x <= b_x;
      a_y <= b_y;
    end
    s1_dxb   <= bx_s - ax_s;
    s1_dyp   <= py_s - ay_s;
    s1_dyb   <= by_s - ay_s;
    s1_dxp   <= px_s - ax_s;
    s1_box   <= box;
    s1_str   <= str;
    s1_dypos <= dypos;
    s2_rhs   <= PW'(s1_dxb * s1_dyp);
    s2_lhs   <= PW'(s1_dyb * s1_dxp);
    s2_box   <= s1_box;
    s2_str   <= s1_str;
    s2_dypos <= s1_dypos;
  end

  assign stat.busy = s1_v | s2_v;
  assign stat.bnd  = bnd;
  assign stat.odd  = odd;

endmodule

// ===== rtl/polygon_point_containment_top.sv =====
// Top level: polygon vertex list with clear, append and point test.
//
//   channel | direction | handshake           | beat fields
//   --------+-----------+---------------------+-----------------------------------------
//   in      | to block  | in_valid / in_stall | op, x, y
//   out     | from block| out_valid/out_stall | inside_res, on_boundary, count, overflow
//
// Clear, append and a test on fewer than three vertices go from idle straight to finish.
// A test on n vertices runs through scan, drain and finish: the vertex memory read port
// delivers one edge per cycle into a three-stage edge pipeline.
// Reset zeroes the vertex count; the vertex memory is not cleared.
// A new beat is taken while a result still waits in the output register;
// the next beat after that waits until the output register frees.
module polygon_point_containment_top #(
  parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = ppc_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [COORD_BITS-1:0]               x,
  input  logic [COORD_BITS-1:0]               y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                inside_res,
  output logic                                on_boundary,
  output logic [$clog2(MAX_VERTICES + 1)-1:0] count,
  output logic                                overflow
);

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int VW    = 2 * COORD_BITS;

  ppc_pkg::state_t state, state_next;

  logic [CNT_W-1:0]      vtx_cnt;
  logic [CNT_W-1:0]      scan_idx;
  logic [COORD_BITS-1:0] last_x, last_y;
  logic [COORD_BITS-1:0] px, py;
  logic                  res_inside, res_bnd, res_ovf;

  logic                  accept, is_same, is_full, can_test;
  logic                  do_clear, do_append, do_drop, do_start;
  logic                  scan_last, drain_done, out_free, out_load;

  logic                  rd_valid;
  logic [VW-1:0]         rd_data;
  ppc_pkg::edge_stat_t   estat;

  // Decode of the incoming beat; input is open only in idle
  always_comb begin
    accept     = in_valid && (state == ppc_pkg::ST_IDLE);
    is_same    = (vtx_cnt != '0) && (last_x == x) && (last_y == y);
    is_full    = (vtx_cnt == CNT_W'(MAX_VERTICES));
    can_test   = (vtx_cnt >= CNT_W'(ppc_pkg::MIN_POLY_VERTICES));
    do_clear   = accept && (op == ppc_pkg::OP_CLEAR);
    do_append  = accept && (op == ppc_pkg::OP_APPEND) && !is_same && !is_full;
    do_drop    = accept && (op == ppc_pkg::OP_APPEND) && !is_same && is_full;
    do_start   = accept && (op == ppc_pkg::OP_TEST) && can_test;
    scan_last  = (scan_idx == vtx_cnt - 1'b1);
    drain_done = !rd_valid && !estat.busy;
    out_free   = !out_valid || !out_stall;
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state)
      ppc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept) begin
          state_next = do_start ? ppc_pkg::ST_SCAN : ppc_pkg::ST_FIN;
        end
      end
      ppc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_next = ppc_pkg::ST_DRAIN;
        end
      end
      ppc_pkg::ST_DRAIN: begin
        if (drain_done) begin
          state_next = ppc_pkg::ST_FIN;
        end
      end
      ppc_pkg::ST_FIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ppc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ppc_pkg::ST_IDLE;
      vtx_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_clear) begin
        vtx_cnt <= '0;
      end else if (do_append) begin
        vtx_cnt <= vtx_cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (do_append) begin
      last_x <= x;
      last_y <= y;
    end
    if (accept) begin
      px         <= x;
      py         <= y;
      res_inside <= 1'b0;
      res_bnd    <= 1'b0;
      res_ovf    <= do_drop;
    end else if (state == ppc_pkg::ST_DRAIN && drain_done) begin
      res_inside <= estat.bnd | estat.odd;
      res_bnd    <= estat.bnd;
    end
    if (do_start) begin
      scan_idx <= '0;
    end else if (state == ppc_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (out_load) begin
      inside_res  <= res_inside;
      on_boundary <= res_bnd;
      count       <= vtx_cnt;
      overflow    <= res_ovf;
    end
  end

  // Vertex memory; no writes happen while a scan reads it
  ppc_vram #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (VW)
  ) u_vram (
    .clk    (clk),
    .rst    (rst),
    .we     (do_append),
    .waddr  (vtx_cnt[AW-1:0]),
    .wdata  ({x, y}),
    .re     (state == ppc_pkg::ST_SCAN),
    .raddr  (scan_idx[AW-1:0]),
    .rdata  (rd_data),
    .rvalid (rd_valid)
  );

  // Edge pipeline; the first edge closes from the last vertex
  ppc_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk      (clk),
    .rst      (rst),
    .start    (do_start),
    .a_init_x (last_x),
    .a_init_y (last_y),
    .p_x      (px),
    .p_y      (py),
    .b_valid  (rd_valid),
    .b_x      (rd_data[VW-1:COORD_BITS]),
    .b_y      (rd_data[COORD_BITS-1:0]),
    .stat     (estat)
  );

endmodule

// ===== rtl/ppc_chk.sv =====
// Port-level checker for the polygon point containment block, with its bind.
module ppc_chk #(
  parameter int MAX_VERTICES = ppc_pkg::MAX_VERTICES_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                inside_res,
  input logic                                on_boundary,
  input logic [$clog2(MAX_VERTICES + 1)-1:0] count,
  input logic                                overflow
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Output register comes up empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res) &&
      $stable(on_boundary) && $stable(count) && $stable(overflow))
    else $error("stalled result beat changed");

  // A point on an edge is always reported inside
  a_bnd_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && on_boundary |-> inside_res)
    else $error("on_boundary without inside_res");

  // Inside needs a real polygon
  a_inside_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_res |-> count >= CNT_W'(ppc_pkg::MIN_POLY_VERTICES))
    else $error("inside reported with too few vertices");

  // A dropped append only happens on a full list
  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> count == CNT_W'(MAX_VERTICES))
    else $error("overflow with list not full");

endmodule

bind polygon_point_containment_top ppc_chk #(
  .MAX_VERTICES (MAX_VERTICES)
) u_ppc_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .inside_res  (inside_res),
  .on_boundary (on_boundary),
  .count       (count),
  .overflow    (overflow)
);
